// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// Each macro expands to one labeled concurrent assertion on a rising clock.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge while reset is low.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/smd_pkg.sv =====
// ----------------------------------------------------------------------------
// smd_pkg
// Shared types and constants for the sorted merge with duplicate removal.
// ----------------------------------------------------------------------------
`default_nettype none

package smd_pkg;

   // Default number of entries in each list store.
   localparam int DEPTH_DEFAULT = 32;

   // Width of one list element.
   localparam int DATA_W = 32;

   // Width of the operation code on the request side.
   localparam int OP_W = 2;

   // Operation codes carried on the request tuser.
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_A = 2'd0,
      OP_PUSH_B = 2'd1,
      OP_RUN    = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // Sequencer states, one-hot.
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SEL   = 4'b0010,
      ST_EMIT  = 4'b0100,
      ST_FINAL = 4'b1000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/smd_ram.sv =====
// ----------------------------------------------------------------------------
// smd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module smd_ram #(
   parameter  int WIDTH  = 32,
   parameter  int DEPTH  = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/sorted_merge_dedup.sv =====
// ----------------------------------------------------------------------------
// sorted_merge_dedup
// Merges two pushed lists of signed values and drops repeated values.
// ----------------------------------------------------------------------------
// A push beat (tuser 0 for list A, 1 for list B) is taken while the block is
// idle and leaves it ready; a push into a full list is dropped and sets the
// overflow flag. A run beat (tuser 2) keeps the block busy through a select
// and an emit state per merged element and a final state, and longer while
// the result side stalls. Each element needs both states for the one signed
// comparator, shared by the head compare of the merge and the compare with
// the pending element in thinning, and for the registered list RAM reads. A
// run with both lists empty gives no beat and only clears the overflow flag.
// Result beats carry the element in tdata, the final one is marked by tlast,
// and tuser carries the overflow flag as it stood when the run began.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sorted_merge_dedup #(
   parameter int DEPTH = smd_pkg::DEPTH_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [smd_pkg::DATA_W-1:0] req_tdata,  // [31:0] value
   input  wire logic [smd_pkg::OP_W-1:0]   req_tuser,  // [1:0] operation
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [smd_pkg::DATA_W-1:0] rsp_tdata,  // [31:0] value_res
   output logic                           rsp_tlast,
   output logic                           rsp_tuser   // [0] overflow
);

   import smd_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   state_type state_ff, state_in;

   logic [CW-1:0] cnt_a_ff, cnt_a_in;
   logic [CW-1:0] cnt_b_ff, cnt_b_in;
   logic [CW-1:0] ia_ff, ia_in;
   logic [CW-1:0] ib_ff, ib_in;
   logic          ovf_ff, ovf_in;
   logic          have_pend_ff, have_pend_in;
   logic [DATA_W-1:0] pend_ff, pend_in;
   logic [DATA_W-1:0] cand_ff, cand_in;

   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_data_ff, out_data_in;
   logic              out_last_ff, out_last_in;
   logic              out_ovf_ff, out_ovf_in;

   logic              accept;
   op_type            op;
   logic              out_load;
   logic              wr_a, wr_b;
   logic [DATA_W-1:0] a_dat, b_dat;
   logic              a_left, b_left;
   logic [DATA_W-1:0] cmp_x, cmp_y;
   logic              cmp_lt;
   logic              take_a;
   logic              emit_need;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign out_load   = !out_valid_ff || rsp_tready;

   // Push writes land at the current fill count of the chosen list.
   assign wr_a = accept && (op == OP_PUSH_A) && (cnt_a_ff != FULL);
   assign wr_b = accept && (op == OP_PUSH_B) && (cnt_b_ff != FULL);

   smd_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (cnt_a_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (ia_ff[AW-1:0]),
      .rd_data (a_dat)
   );

   smd_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (cnt_b_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (ib_ff[AW-1:0]),
      .rd_data (b_dat)
   );

   assign a_left = (ia_ff != cnt_a_ff);
   assign b_left = (ib_ff != cnt_b_ff);

   // Shared signed comparator: list heads while selecting, pending against
   // candidate while thinning.
   always_comb begin
      if (state_ff == ST_SEL) begin
         cmp_x = a_dat;
         cmp_y = b_dat;
      end else begin
         cmp_x = pend_ff;
         cmp_y = cand_ff;
      end
   end
   assign cmp_lt = $signed(cmp_x) < $signed(cmp_y);

   // Ties go to list B.
   assign take_a    = a_left && (!b_left || cmp_lt);
   assign emit_need = have_pend_ff && cmp_lt;

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in     = state_ff;
      cnt_a_in     = cnt_a_ff;
      cnt_b_in     = cnt_b_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      ovf_in       = ovf_ff;
      have_pend_in = have_pend_ff;
      pend_in      = pend_ff;
      cand_in      = cand_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (op)
                  OP_PUSH_A: begin
                     if (cnt_a_ff == FULL) begin
                        ovf_in = 1'b1;
                     end else begin
                        cnt_a_in = cnt_a_ff + CW'(1);
                     end
                  end
                  OP_PUSH_B: begin
                     if (cnt_b_ff == FULL) begin
                        ovf_in = 1'b1;
                     end else begin
                        cnt_b_in = cnt_b_ff + CW'(1);
                     end
                  end
                  OP_RUN: begin
                     have_pend_in = 1'b0;
                     if (a_left || b_left) begin
                        state_in = ST_SEL;
                     end else begin
                        ovf_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SEL: begin
            if (take_a) begin
               cand_in = a_dat;
               ia_in   = ia_ff + CW'(1);
            end else begin
               cand_in = b_dat;
               ib_in   = ib_ff + CW'(1);
            end
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (!emit_need || out_load) begin
               if (emit_need) begin
                  out_valid_in = 1'b1;
                  out_data_in  = pend_ff;
                  out_last_in  = 1'b0;
                  out_ovf_in   = ovf_ff;
               end
               pend_in      = cand_ff;
               have_pend_in = 1'b1;
               if (a_left || b_left) begin
                  state_in = ST_SEL;
               end else begin
                  state_in = ST_FINAL;
               end
            end
         end

         ST_FINAL: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               out_data_in  = pend_ff;
               out_last_in  = 1'b1;
               out_ovf_in   = ovf_ff;
               cnt_a_in     = '0;
               cnt_b_in     = '0;
               ia_in        = '0;
               ib_in        = '0;
               ovf_in       = 1'b0;
               have_pend_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         ia_ff        <= '0;
         ib_ff        <= '0;
         ovf_ff       <= 1'b0;
         have_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         ia_ff        <= ia_in;
         ib_ff        <= ib_in;
         ovf_ff       <= ovf_in;
         have_pend_ff <= have_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_ff     <= pend_in;
      cand_ff     <= cand_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      out_ovf_ff  <= out_ovf_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

   // Checks on the sequencer.
   `ASSERT_ALWAYS(a_cnt_bound, clock, reset, (cnt_a_ff <= FULL) && (cnt_b_ff <= FULL), "list count beyond depth")
   `ASSERT_ALWAYS(a_idx_bound, clock, reset, (ia_ff <= cnt_a_ff) && (ib_ff <= cnt_b_ff), "read index passed fill count")
   `ASSERT_NEXT(a_run_busy, clock, reset, accept && (op == OP_RUN) && (a_left || b_left), !req_tready, "run with data did not start")
   `ASSERT_NEXT(a_final_last, clock, reset, (state_ff == ST_FINAL) && out_load, rsp_tvalid && rsp_tlast && req_tready, "final beat not marked last")

endmodule

`default_nettype wire
